// ===== design/rtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg
// shared types, constants and the month length function of the calendar clock
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int unsigned ADC_BITS         = 10;
  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned CENTI_W =
    ($clog2(TICKS_PER_SECOND) > 7) ? $clog2(TICKS_PER_SECOND) : 7;

  localparam logic [CENTI_W-1:0] CENTI_LAST  = CENTI_W'(TICKS_PER_SECOND - 1);
  localparam logic [5:0]         SIXTY_LAST  = 6'd59;
  localparam logic [4:0]         HOUR_LAST   = 5'd23;
  localparam logic [3:0]         MONTH_LAST  = 4'd12;
  localparam logic [6:0]         YEAR_LAST   = 7'd99;
  localparam logic [6:0]         YEAR_NOLEAP = 7'd100;

  typedef enum logic [2:0] {
    MODE_SET_YEAR   = 3'd0,
    MODE_SET_MONTH  = 3'd1,
    MODE_SET_DAY    = 3'd2,
    MODE_SET_HOUR   = 3'd3,
    MODE_SET_MINUTE = 3'd4,
    MODE_SET_SECOND = 3'd5,
    MODE_WAIT       = 3'd6,
    MODE_RUN        = 3'd7
  } mode_t;

  typedef struct packed {
    logic [6:0]         year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [CENTI_W-1:0] centi;
  } rtc_time_t;

  typedef struct packed {
    logic                action;
    logic [ADC_BITS-1:0] adc;
    logic                next_level;
    logic                next_later;
    logic                start_level;
    logic                start_later;
  } item_t;

  // days in month, years counted from 2000
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [6:0] y);
    logic       leap;
    logic [3:0] mm;
    logic [4:0] days;
    leap = (y[1:0] == 2'b00) && (y != YEAR_NOLEAP);
    mm   = m;
    if (m == 4'd0) begin
      mm = 4'd1;
    end else if (m > MONTH_LAST) begin
      mm = MONTH_LAST;
    end
    case (mm)
      4'd2:                      days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

endpackage
`default_nettype wire

// ===== design/rtc_tick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_tick
// one-tick advance of the time with the carry cascade up to the year
// ----------------------------------------------------------------------------
module rtc_tick (
  input  rtc_pkg::rtc_time_t time_i,
  output rtc_pkg::rtc_time_t time_o
);
  import rtc_pkg::*;

  logic       c_wrap, s_wrap, m_wrap, h_wrap, d_wrap, mo_wrap;
  logic [4:0] last_day;

  always_comb begin
    last_day = month_days(time_i.month, time_i.year);
    c_wrap   = (time_i.centi >= CENTI_LAST);
    s_wrap   = c_wrap && (time_i.second >= SIXTY_LAST);
    m_wrap   = s_wrap && (time_i.minute >= SIXTY_LAST);
    h_wrap   = m_wrap && (time_i.hour >= HOUR_LAST);
    d_wrap   = h_wrap && (time_i.day >= last_day);
    mo_wrap  = d_wrap && (time_i.month >= MONTH_LAST);

    time_o        = time_i;
    time_o.centi  = c_wrap ? '0 : time_i.centi + CENTI_W'(1);
    if (c_wrap) begin
      time_o.second = s_wrap ? 6'd0 : time_i.second + 6'd1;
    end
    if (s_wrap) begin
      time_o.minute = m_wrap ? 6'd0 : time_i.minute + 6'd1;
    end
    if (m_wrap) begin
      time_o.hour = h_wrap ? 5'd0 : time_i.hour + 5'd1;
    end
    if (h_wrap) begin
      time_o.day = d_wrap ? 5'd1 : time_i.day + 5'd1;
    end
    if (d_wrap) begin
      time_o.month = mo_wrap ? 4'd1 : time_i.month + 4'd1;
    end
    if (mo_wrap) begin
      time_o.year = (time_i.year >= YEAR_LAST) ? 7'd0 : time_i.year + 7'd1;
    end
  end

endmodule
`default_nettype wire

// ===== design/rtc_setmap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_setmap
// scales the potentiometer sample onto the range of the field being set
// ----------------------------------------------------------------------------
module rtc_setmap (
  input  rtc_pkg::mode_t                mode_i,
  input  rtc_pkg::rtc_time_t            time_i,
  input  logic [rtc_pkg::ADC_BITS-1:0]  adc_i,
  output logic [6:0]                    value_o
);
  import rtc_pkg::*;

  logic [6:0]            lo;
  logic [6:0]            span;
  logic [7:0]            range_v;
  logic [ADC_BITS+7:0]   prod;
  logic [7:0]            scaled;
  logic [7:0]            clamped;
  logic [4:0]            days;

  always_comb begin
    days = month_days(time_i.month, time_i.year);
    case (mode_i)
      MODE_SET_YEAR:   begin lo = 7'd0; span = 7'd99; end
      MODE_SET_MONTH:  begin lo = 7'd1; span = 7'd11; end
      MODE_SET_DAY:    begin lo = 7'd1; span = {2'b00, days} - 7'd1; end
      MODE_SET_HOUR:   begin lo = 7'd0; span = 7'd23; end
      MODE_SET_MINUTE: begin lo = 7'd0; span = 7'd59; end
      MODE_SET_SECOND: begin lo = 7'd0; span = 7'd59; end
      default:         begin lo = 7'd0; span = 7'd0;  end
    endcase
    range_v = {1'b0, span} + 8'd1;
    prod    = {8'd0, adc_i} * {{ADC_BITS{1'b0}}, range_v};
    scaled  = prod[ADC_BITS +: 8];
    clamped = (scaled > {1'b0, span}) ? {1'b0, span} : scaled;
    value_o = lo + clamped[6:0];
  end

endmodule
`default_nettype wire

// ===== design/rtc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_ctrl
// time and mode registers, button edge detection and the setting sequence
// ----------------------------------------------------------------------------
module rtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  rtc_pkg::item_t     item,
  output rtc_pkg::rtc_time_t time_o,
  output rtc_pkg::mode_t     mode_o,
  output logic               upd_o
);
  import rtc_pkg::*;

  rtc_time_t time_r, time_nxt, time_adv;
  mode_t     mode_r, mode_nxt;
  logic      next_last_r, next_last_nxt;
  logic      start_last_r, start_last_nxt;
  logic      upd_r, upd_nxt;
  logic [6:0] set_val;
  logic      next_edge, start_edge, in_setting;

  rtc_tick u_tick (
    .time_i (time_r),
    .time_o (time_adv)
  );

  rtc_setmap u_setmap (
    .mode_i  (mode_r),
    .time_i  (time_r),
    .adc_i   (item.adc),
    .value_o (set_val)
  );

  assign next_edge  = !item.next_level && next_last_r && !item.next_later;
  assign start_edge = !item.start_level && start_last_r && !item.start_later;
  assign in_setting = (mode_r != MODE_WAIT) && (mode_r != MODE_RUN);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (adv && item.action) begin
      if (in_setting && next_edge) begin
        mode_nxt = mode_t'(3'(mode_r + 3'd1));
      end else if ((mode_r == MODE_WAIT) && start_edge) begin
        mode_nxt = MODE_RUN;
      end
    end
  end

  // time, edge history and update flag
  always_comb begin
    time_nxt       = time_r;
    next_last_nxt  = next_last_r;
    start_last_nxt = start_last_r;
    upd_nxt        = upd_r;
    if (adv) begin
      upd_nxt = !item.action && (mode_r == MODE_RUN);
      if (!item.action) begin
        if (mode_r == MODE_RUN) begin
          time_nxt = time_adv;
        end
      end else begin
        case (mode_r)
          MODE_SET_YEAR:   time_nxt.year   = set_val;
          MODE_SET_MONTH:  time_nxt.month  = set_val[3:0];
          MODE_SET_DAY:    time_nxt.day    = set_val[4:0];
          MODE_SET_HOUR:   time_nxt.hour   = set_val[4:0];
          MODE_SET_MINUTE: time_nxt.minute = set_val[5:0];
          MODE_SET_SECOND: time_nxt.second = set_val[5:0];
          MODE_WAIT: begin
            start_last_nxt = item.start_level;
            if (start_edge) begin
              time_nxt.centi = '0;
            end
          end
          default: ;
        endcase
        if (in_setting) begin
          next_last_nxt = item.next_level;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r.year   <= 7'd0;
      time_r.month  <= 4'd1;
      time_r.day    <= 5'd1;
      time_r.hour   <= 5'd0;
      time_r.minute <= 6'd0;
      time_r.second <= 6'd0;
      time_r.centi  <= '0;
      mode_r        <= MODE_SET_YEAR;
      next_last_r   <= 1'b1;
      start_last_r  <= 1'b1;
      upd_r         <= 1'b0;
    end else begin
      time_r        <= time_nxt;
      mode_r        <= mode_nxt;
      next_last_r   <= next_last_nxt;
      start_last_r  <= start_last_nxt;
      upd_r         <= upd_nxt;
    end
  end

  assign time_o = time_r;
  assign mode_o = mode_r;
  assign upd_o  = upd_r;

  a_upd_running: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r |-> (mode_r == MODE_RUN))
    else $error("display update outside running mode");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(time_r) && $stable(mode_r)))
    else $error("state changed without a transaction");

  a_mode_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (mode_r != MODE_WAIT) && (mode_r != MODE_RUN)) |=>
      ((mode_r == $past(mode_r)) || (3'(mode_r) == 3'($past(mode_r) + 3'd1))))
    else $error("setting mode skipped a step");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.day != 5'd0) && (time_r.day <= month_days(time_r.month, time_r.year)))
    else $error("day outside its month");

endmodule
`default_nettype wire

// ===== design/calendar_clock_with_setting_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_with_setting_core
// calendar clock for 2000 to 2099 with potentiometer setting and start button
// ----------------------------------------------------------------------------
// Every input transaction (a tick or a control poll) yields exactly one result
// transaction showing the time and mode after it. The block takes one
// transaction per cycle while out_ready is high: an input register feeds the
// update logic, and the clock registers themselves form the result register,
// so a result stays held while out_ready is low. While a result waits, the
// input register can still take one transaction; once it holds one, in_ready
// stays low until the result is taken.
module calendar_clock_with_setting_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [rtc_pkg::ADC_BITS-1:0] in_adc_value,
  input  logic                         in_next_level,
  input  logic                         in_next_level_later,
  input  logic                         in_start_level,
  input  logic                         in_start_level_later,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [6:0]                   out_year_out,
  output logic [3:0]                   out_month_out,
  output logic [4:0]                   out_day_out,
  output logic [4:0]                   out_hour_out,
  output logic [5:0]                   out_minute_out,
  output logic [5:0]                   out_second_out,
  output logic [6:0]                   out_centi_out,
  output logic [2:0]                   out_mode_out,
  output logic                         out_display_update
);
  import rtc_pkg::*;

  item_t     item_r;
  logic      in_valid_r;
  logic      out_valid_r;
  logic      adv;
  rtc_time_t time_cur;
  mode_t     mode_cur;
  logic      upd_cur;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action      <= in_action;
      item_r.adc         <= in_adc_value;
      item_r.next_level  <= in_next_level;
      item_r.next_later  <= in_next_level_later;
      item_r.start_level <= in_start_level;
      item_r.start_later <= in_start_level_later;
    end
  end

  rtc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .time_o (time_cur),
    .mode_o (mode_cur),
    .upd_o  (upd_cur)
  );

  assign out_valid          = out_valid_r;
  assign out_year_out       = time_cur.year;
  assign out_month_out      = time_cur.month;
  assign out_day_out        = time_cur.day;
  assign out_hour_out       = time_cur.hour;
  assign out_minute_out     = time_cur.minute;
  assign out_second_out     = time_cur.second;
  assign out_centi_out      = time_cur.centi[6:0];
  assign out_mode_out       = mode_cur;
  assign out_display_update = upd_cur;

endmodule
`default_nettype wire

// ===== tb/sv/calendar_clock_with_setting_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_with_setting_core_test
// self-checking testbench for the calendar clock with potentiometer setting
// ----------------------------------------------------------------------------
// A short directed table exercises the year setting extremes, the debounce
// cases and ignored ticks. Random traffic then walks the six setting modes
// with noisy polls and bounced buttons, lands on a time just before a day,
// month or year rollover, starts the clock and ticks through the carries.
// Every result transaction is compared against an in-bench calendar model
// while both handshake sides idle and stall in several pacing phases.
// ----------------------------------------------------------------------------
module calendar_clock_with_setting_core_test;
  import rtc_pkg::*;

  localparam logic        ACT_TICK     = 1'b0;
  localparam logic        ACT_POLL     = 1'b1;
  localparam int unsigned RANDOM_ITEMS = 1160;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE_LEN    = 150;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] centi;
    mode_t      mode;
    logic       display_update;
  } clock_view_t;

  typedef struct packed {
    item_t       stim;
    logic        typed;
    clock_view_t want;
  } directed_row_t;

  localparam clock_view_t RESET_VIEW = '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                                         minute: 6'd0, second: 6'd0, centi: 7'd0,
                                         mode: MODE_SET_YEAR, display_update: 1'b0};

  logic                clk                  = 1'b0;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic                in_action            = 1'b0;
  logic [ADC_BITS-1:0] in_adc_value         = '0;
  logic                in_next_level        = 1'b1;
  logic                in_next_level_later  = 1'b1;
  logic                in_start_level       = 1'b1;
  logic                in_start_level_later = 1'b1;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [6:0]          out_year_out;
  logic [3:0]          out_month_out;
  logic [4:0]          out_day_out;
  logic [4:0]          out_hour_out;
  logic [5:0]          out_minute_out;
  logic [5:0]          out_second_out;
  logic [6:0]          out_centi_out;
  logic [2:0]          out_mode_out;
  logic                out_display_update;

  // calendar model state
  logic [6:0] cal_year   = 7'd0;
  logic [3:0] cal_month  = 4'd1;
  logic [4:0] cal_day    = 5'd1;
  logic [4:0] cal_hour   = 5'd0;
  logic [5:0] cal_minute = 6'd0;
  logic [5:0] cal_second = 6'd0;
  logic [6:0] cal_centi  = 7'd0;
  mode_t      cal_mode   = MODE_SET_YEAR;
  logic       next_last  = 1'b1;
  logic       start_last = 1'b1;

  clock_view_t expected_views [$];
  int unsigned counted_items      = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles       = 0;
  logic        mismatch_seen      = 1'b0;

  calendar_clock_with_setting_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_adc_value         (in_adc_value),
    .in_next_level        (in_next_level),
    .in_next_level_later  (in_next_level_later),
    .in_start_level       (in_start_level),
    .in_start_level_later (in_start_level_later),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year_out         (out_year_out),
    .out_month_out        (out_month_out),
    .out_day_out          (out_day_out),
    .out_hour_out         (out_hour_out),
    .out_minute_out       (out_minute_out),
    .out_second_out       (out_second_out),
    .out_centi_out        (out_centi_out),
    .out_mode_out         (out_mode_out),
    .out_display_update   (out_display_update)
  );

  always #6 clk = ~clk;

  function automatic int unsigned month_length(input logic [3:0] m, input logic [6:0] y);
    int unsigned full_year;
    logic [3:0]  mm;
    full_year = 2000 + y;
    mm = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
    case (mm)
      4'd2: begin
        if (((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0)) begin
          return 29;
        end
        return 28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned scale_sample(input int unsigned adc, input int unsigned lo,
                                               input int unsigned hi);
    int unsigned span;
    int unsigned v;
    span = hi - lo;
    v = (adc * (span + 1)) >> ADC_BITS;
    if (v > span) begin
      v = span;
    end
    return lo + v;
  endfunction

  task automatic step_calendar(input item_t it, output clock_view_t view);
    logic upd;
    upd = 1'b0;
    if (it.action == ACT_TICK) begin
      if (cal_mode == MODE_RUN) begin
        upd = 1'b1;
        if (cal_centi < TICKS_PER_SECOND - 1) begin
          cal_centi++;
        end else begin
          cal_centi = '0;
          if (cal_second < 6'd59) begin
            cal_second++;
          end else begin
            cal_second = '0;
            if (cal_minute < 6'd59) begin
              cal_minute++;
            end else begin
              cal_minute = '0;
              if (cal_hour < 5'd23) begin
                cal_hour++;
              end else begin
                cal_hour = '0;
                if (cal_day < month_length(cal_month, cal_year)) begin
                  cal_day++;
                end else begin
                  cal_day = 5'd1;
                  if (cal_month < 4'd12) begin
                    cal_month++;
                  end else begin
                    cal_month = 4'd1;
                    cal_year = (cal_year >= 7'd99) ? 7'd0 : cal_year + 7'd1;
                  end
                end
              end
            end
          end
        end
      end
    end else if (cal_mode < MODE_WAIT) begin
      case (cal_mode)
        MODE_SET_YEAR:   cal_year   = 7'(scale_sample(it.adc, 0, 99));
        MODE_SET_MONTH:  cal_month  = 4'(scale_sample(it.adc, 1, 12));
        MODE_SET_DAY:    cal_day    = 5'(scale_sample(it.adc, 1, month_length(cal_month, cal_year)));
        MODE_SET_HOUR:   cal_hour   = 5'(scale_sample(it.adc, 0, 23));
        MODE_SET_MINUTE: cal_minute = 6'(scale_sample(it.adc, 0, 59));
        default:         cal_second = 6'(scale_sample(it.adc, 0, 59));
      endcase
      if (!it.next_level && next_last && !it.next_later) begin
        cal_mode = mode_t'(cal_mode + 3'd1);
      end
      next_last = it.next_level;
    end else if (cal_mode == MODE_WAIT) begin
      if (!it.start_level && start_last && !it.start_later) begin
        cal_centi = '0;
        cal_mode = MODE_RUN;
      end
      start_last = it.start_level;
    end
    view = '{cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second, cal_centi,
             cal_mode, upd};
  endtask

  function automatic item_t stim(input logic action, input logic [ADC_BITS-1:0] adc,
                                 input logic nl, input logic nll, input logic sl,
                                 input logic sll);
    item_t it;
    it.action      = action;
    it.adc         = adc;
    it.next_level  = nl;
    it.next_later  = nll;
    it.start_level = sl;
    it.start_later = sll;
    return it;
  endfunction

  // random levels, with bounce forced wherever a clean press would slip through
  function automatic item_t random_item(input logic action);
    item_t it;
    it.action = action;
    case ($urandom_range(7))
      0: it.adc = '0;
      1: it.adc = '1;
      default: it.adc = ADC_BITS'($urandom);
    endcase
    it.next_level  = 1'($urandom);
    it.next_later  = 1'($urandom);
    it.start_level = 1'($urandom);
    it.start_later = 1'($urandom);
    if (!it.next_level && next_last && cal_mode < MODE_WAIT) begin
      it.next_later = 1'b1;
    end
    if (!it.start_level && start_last && cal_mode == MODE_WAIT) begin
      it.start_later = 1'b1;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed = 1'b0,
                           input clock_view_t typed_view = '0);
    clock_view_t view;
    case ((counted_items / PHASE_LEN) % 4)
      0: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct    = 87;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 87;
      end
      default: begin
        sender_idle_pct    = 21;
        receiver_stall_pct = 21;
      end
    endcase
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_action            <= it.action;
    in_adc_value         <= it.adc;
    in_next_level        <= it.next_level;
    in_next_level_later  <= it.next_later;
    in_start_level       <= it.start_level;
    in_start_level_later <= it.start_later;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    counted_items++;
    step_calendar(it, view);
    expected_views.push_back(typed ? typed_view : view);
    @(negedge clk);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    clock_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatch_seen = 1'b1;
      end else begin
        want = expected_views.pop_front();
        compare_field("year_out", want.year, out_year_out);
        compare_field("month_out", want.month, out_month_out);
        compare_field("day_out", want.day, out_day_out);
        compare_field("hour_out", want.hour, out_hour_out);
        compare_field("minute_out", want.minute, out_minute_out);
        compare_field("second_out", want.second, out_second_out);
        compare_field("centi_out", want.centi, out_centi_out);
        compare_field("mode_out", want.mode, out_mode_out);
        compare_field("display_update", want.display_update, out_display_update);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("** calendar_clock_with_setting_core: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    directed_row_t plan [$];
    clock_view_t   year_top_view;
    item_t         it;
    int unsigned   tgt_year;
    int unsigned   tgt_month;
    int unsigned   tgt_day;
    int unsigned   span_count;
    int unsigned   want_off;
    int unsigned   lo;
    int unsigned   hi;
    logic [ADC_BITS-1:0] adc;

    year_top_view      = RESET_VIEW;
    year_top_view.year = 7'd99;

    // ignored tick, year extremes and rounding boundary
    plan.push_back('{stim(ACT_TICK, 10'd0, 1, 1, 1, 1), 1'b1, RESET_VIEW});
    plan.push_back('{stim(ACT_POLL, 10'd0, 1, 1, 1, 1), 1'b1, RESET_VIEW});
    plan.push_back('{stim(ACT_POLL, 10'd1023, 1, 1, 1, 1), 1'b1, year_top_view});
    plan.push_back('{stim(ACT_POLL, 10'd1013, 1, 1, 1, 1), 1'b0, '0});
    plan.push_back('{stim(ACT_POLL, 10'd1014, 1, 1, 1, 1), 1'b0, '0});
    // bounced press, held press, release
    plan.push_back('{stim(ACT_POLL, 10'h155, 0, 1, 1, 1), 1'b0, '0});
    plan.push_back('{stim(ACT_POLL, 10'h2aa, 0, 0, 1, 1), 1'b0, '0});
    plan.push_back('{stim(ACT_POLL, 10'd512, 1, 0, 1, 1), 1'b0, '0});
    plan.push_back('{stim(ACT_TICK, 10'd1023, 0, 0, 0, 0), 1'b0, '0});
    // start button has no effect while setting
    plan.push_back('{stim(ACT_POLL, 10'd300, 1, 1, 0, 0), 1'b0, '0});
    plan.push_back('{stim(ACT_POLL, 10'd1, 1, 1, 1, 1), 1'b0, '0});

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_item(plan[i].stim, plan[i].typed, plan[i].want);
    end

    // aim for a moment just before midnight at the end of some month
    tgt_year  = $urandom_range(99);
    tgt_month = $urandom_range(12, 1);
    if ($urandom_range(3) == 0) begin
      tgt_year  = 99;
      tgt_month = 12;
    end
    tgt_day = month_length(4'(tgt_month), 7'(tgt_year));

    while (cal_mode < MODE_WAIT) begin
      repeat ($urandom_range(45, 15)) begin
        send_item(random_item(($urandom_range(15) == 0) ? ACT_TICK : ACT_POLL));
      end
      case (cal_mode)
        MODE_SET_YEAR: begin
          span_count = 100;
          want_off   = tgt_year;
        end
        MODE_SET_MONTH: begin
          span_count = 12;
          want_off   = tgt_month - 1;
        end
        MODE_SET_DAY: begin
          span_count = month_length(cal_month, cal_year);
          want_off   = tgt_day - 1;
        end
        MODE_SET_HOUR: begin
          span_count = 24;
          want_off   = 23;
        end
        default: begin
          span_count = 60;
          want_off   = 59;
        end
      endcase
      lo  = (want_off * (1 << ADC_BITS) + span_count - 1) / span_count;
      hi  = ((want_off + 1) * (1 << ADC_BITS) + span_count - 1) / span_count - 1;
      adc = ADC_BITS'($urandom_range(hi, lo));
      it            = random_item(ACT_POLL);
      it.adc        = adc;
      it.next_level = 1'b1;
      send_item(it);
      it            = random_item(ACT_POLL);
      it.adc        = adc;
      it.next_level = 1'b0;
      it.next_later = 1'b0;
      send_item(it);
    end

    repeat ($urandom_range(40, 15)) begin
      send_item(random_item(($urandom_range(7) == 0) ? ACT_TICK : ACT_POLL));
    end
    it             = random_item(ACT_POLL);
    it.start_level = 1'b1;
    send_item(it);
    it             = random_item(ACT_POLL);
    it.start_level = 1'b0;
    it.start_later = 1'b0;
    send_item(it);

    while (counted_items < RANDOM_ITEMS) begin
      send_item(random_item(($urandom_range(19) == 0) ? ACT_POLL : ACT_TICK));
    end
    in_valid <= 1'b0;

    while (expected_views.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);

    if (!mismatch_seen) begin
      $display("** calendar_clock_with_setting_core: PASSED **");
    end else begin
      $display("** calendar_clock_with_setting_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rtc_pkg.sv
design/rtc_tick.sv
design/rtc_setmap.sv
design/rtc_ctrl.sv
design/calendar_clock_with_setting_core.sv
tb/sv/calendar_clock_with_setting_core_test.sv
